// ===== src/arpc_pkg.sv =====
package arpc_pkg;

  localparam int TableEntries = 8;
  localparam int MaxResults = 8;
  localparam int IdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam int CntW = $clog2(MaxResults + 1);
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 32;
  localparam int MinFrameLen = 28;

  typedef enum logic [1:0] {
    ACT_RESOLVE = 2'd0,
    ACT_PACKET  = 2'd1,
    ACT_TICK    = 2'd2
  } act_e;

  typedef enum logic [1:0] {
    ST_FREE      = 2'd0,
    ST_OK        = 2'd1,
    ST_RESOLVING = 2'd2
  } st_e;

  typedef enum logic [1:0] {
    KIND_RESOLVED = 2'd0,
    KIND_PENDING  = 2'd1,
    KIND_REQUEST  = 2'd2,
    KIND_REPLY    = 2'd3
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_LOCAL_IP     = 3'd0,
    REG_TIMER_PERIOD = 3'd1,
    REG_OK_LIFE      = 3'd2,
    REG_RES_LIFE     = 3'd3,
    REG_RETRY_LIMIT  = 3'd4
  } reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_EMIT2,
    S_TREAD,
    S_TPROC,
    S_FLUSH
  } state_e;

  localparam logic [15:0] HwTypeEth = 16'h0001;
  localparam logic [15:0] ProtoIpv4 = 16'h0800;
  localparam logic [7:0] HwLenEth = 8'd6;
  localparam logic [7:0] ProtoLenIpv4 = 8'd4;
  localparam logic [15:0] OpRequest = 16'd1;
  localparam logic [15:0] OpReply = 16'd2;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] query_ip;
    logic [10:0] frame_len;
    logic [15:0] hw_type;
    logic [15:0] proto_type;
    logic [7:0]  hw_len;
    logic [7:0]  proto_len;
    logic [15:0] opcode;
    logic [31:0] src_ip;
    logic [47:0] src_mac;
    logic [31:0] dst_ip;
  } in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] peer_ip;
    logic [47:0] peer_mac;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [31:0] ip;
    logic [47:0] mac;
    logic [15:0] life;
    logic [7:0]  retries;
  } entry_t;

endpackage

// ===== src/arp_cache_engine.sv =====
// ARP cache of TableEntries entries. Ip, mac, lifetime and retry count sit in one
// synchronous RAM with one read per cycle; the entry status is kept in flops so reset
// frees the whole table at once. A resolve or a table-updating packet walks the RAM one
// entry a cycle and then decides, a miss sending a request ahead of its pending beat; a
// tick reads, then modifies and writes back, each entry in turn. Both may also wait on
// out_ready_i. Dropped packets and unused actions finish in the accept cycle.
// One item is handled at a time; results leave through a one-deep output register.
module arp_cache_engine import arpc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_t                 in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_t                out_data_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  typedef logic [IdxW-1:0] idx_t;
  localparam idx_t LastIdx = idx_t'(TableEntries - 1);

  state_e state_q, state_d;

  logic [31:0] local_ip_q;
  logic [15:0] period_q, ok_life_q, res_life_q;
  logic [7:0]  retry_lim_q;

  entry_t mem [TableEntries];
  entry_t rd_q;
  entry_t mem_wd;
  logic   mem_we;
  idx_t   mem_wa;

  logic [1:0] st_q [TableEntries];
  logic       st_we;
  idx_t       st_wa;
  logic [1:0] st_wd;

  // item context
  logic [31:0] key_q, key_d;
  logic [47:0] smac_q, smac_d;
  logic        learn_q, learn_d, reply_q, reply_d;

  // scan bookkeeping
  idx_t        idx_q, idx_d, chk_idx_q, chk_idx_d;
  logic        iss_done_q, iss_done_d, chk_v_q, chk_v_d;
  logic        found_q, found_d, free_found_q, free_found_d;
  idx_t        hit_idx_q, hit_idx_d, free_idx_q, free_idx_d, vict_idx_q, vict_idx_d;
  logic [1:0]  hit_st_q, hit_st_d;
  logic [47:0] hit_mac_q, hit_mac_d;
  logic [15:0] vict_life_q, vict_life_d;
  logic [CntW-1:0] n_q, n_d;

  // result staging: pr holds the newest result until we know whether it is the last
  logic pr_v_q, pr_v_d;
  out_t pr_q, pr_d;
  logic out_v_q, out_v_d;
  out_t out_q, out_d;

  logic in_fire, out_free, slot_free, pkt_ok, grat, to_us;
  logic [1:0] cur_st;
  logic t_live, t_expire, t_free_it, t_emit;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire = in_valid_i && in_ready_o;
  assign out_valid_o = out_v_q;
  assign out_data_o = out_q;
  assign out_free = !out_v_q || out_ready_i;
  assign slot_free = !pr_v_q || out_free;

  assign pkt_ok = (in_data_i.frame_len >= 11'(MinFrameLen))
               && (in_data_i.hw_type == HwTypeEth) && (in_data_i.proto_type == ProtoIpv4)
               && (in_data_i.hw_len == HwLenEth) && (in_data_i.proto_len == ProtoLenIpv4)
               && ((in_data_i.opcode == OpRequest) || (in_data_i.opcode == OpReply));
  assign grat = (in_data_i.src_ip == in_data_i.dst_ip);
  assign to_us = (in_data_i.dst_ip == local_ip_q);

  assign cur_st = st_q[idx_q];
  assign t_live = (cur_st == ST_OK) || (cur_st == ST_RESOLVING);
  assign t_expire = t_live && !(rd_q.life > period_q);
  assign t_free_it = t_expire && (cur_st == ST_RESOLVING) && (rd_q.retries == 8'd0);
  assign t_emit = t_expire && !t_free_it && (n_q < CntW'(MaxResults));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          case (in_data_i.action)
            ACT_RESOLVE: state_d = S_SCAN;
            ACT_PACKET:  if (pkt_ok && (grat || to_us)) state_d = S_SCAN;
            ACT_TICK:    state_d = S_TREAD;
            default:     state_d = S_IDLE;
          endcase
        end
      end
      S_SCAN:   if (chk_v_q && chk_idx_q == LastIdx) state_d = S_DECIDE;
      S_DECIDE: state_d = (!learn_q && !found_q) ? S_EMIT2 : S_FLUSH;
      S_EMIT2:  if (slot_free) state_d = S_FLUSH;
      S_TREAD:  state_d = S_TPROC;
      S_TPROC: begin
        if (!t_emit || slot_free) state_d = (idx_q == LastIdx) ? S_FLUSH : S_TREAD;
      end
      S_FLUSH:  if (!pr_v_q || out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    idx_t tgt;
    logic push, push_last;
    key_d = key_q;
    smac_d = smac_q;
    learn_d = learn_q;
    reply_d = reply_q;
    idx_d = idx_q;
    iss_done_d = iss_done_q;
    chk_v_d = 1'b0;
    chk_idx_d = idx_q;
    found_d = found_q;
    free_found_d = free_found_q;
    hit_idx_d = hit_idx_q;
    free_idx_d = free_idx_q;
    vict_idx_d = vict_idx_q;
    hit_st_d = hit_st_q;
    hit_mac_d = hit_mac_q;
    vict_life_d = vict_life_q;
    n_d = n_q;
    pr_v_d = pr_v_q;
    pr_d = pr_q;
    mem_we = 1'b0;
    mem_wa = idx_q;
    mem_wd = rd_q;
    st_we = 1'b0;
    st_wa = idx_q;
    st_wd = ST_FREE;
    push = 1'b0;
    push_last = 1'b0;
    tgt = found_q ? hit_idx_q : (free_found_q ? free_idx_q : vict_idx_q);

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          idx_d = '0;
          iss_done_d = 1'b0;
          found_d = 1'b0;
          free_found_d = 1'b0;
          n_d = '0;
          smac_d = in_data_i.src_mac;
          learn_d = (in_data_i.action == ACT_PACKET);
          reply_d = !grat && (in_data_i.opcode == OpRequest);
          key_d = (in_data_i.action == ACT_PACKET) ? in_data_i.src_ip
                                                    : in_data_i.query_ip;
        end
      end
      S_SCAN: begin
        chk_v_d = !iss_done_q;
        if (!iss_done_q) begin
          if (idx_q == LastIdx) iss_done_d = 1'b1;
          else idx_d = idx_q + idx_t'(1);
        end
        if (chk_v_q) begin
          if (!found_q && st_q[chk_idx_q] != ST_FREE && rd_q.ip == key_q) begin
            found_d = 1'b1;
            hit_idx_d = chk_idx_q;
            hit_st_d = st_q[chk_idx_q];
            hit_mac_d = rd_q.mac;
          end
          if (!free_found_q && st_q[chk_idx_q] == ST_FREE) begin
            free_found_d = 1'b1;
            free_idx_d = chk_idx_q;
          end
          // victim only matters when no entry is free, so all lifetimes are written
          if (chk_idx_q == '0 || rd_q.life < vict_life_q) begin
            vict_idx_d = chk_idx_q;
            vict_life_d = rd_q.life;
          end
        end
      end
      S_DECIDE: begin
        if (learn_q) begin
          mem_we = 1'b1;
          mem_wa = tgt;
          mem_wd = '{ip: key_q, mac: smac_q, life: ok_life_q, retries: retry_lim_q};
          st_we = 1'b1;
          st_wa = tgt;
          st_wd = ST_OK;
          if (reply_q) begin
            pr_v_d = 1'b1;
            pr_d = '{kind: KIND_REPLY, peer_ip: key_q, peer_mac: smac_q, last: 1'b0};
          end
        end else if (found_q) begin
          pr_v_d = 1'b1;
          if (hit_st_q == ST_OK)
            pr_d = '{kind: KIND_RESOLVED, peer_ip: key_q, peer_mac: hit_mac_q, last: 1'b0};
          else
            pr_d = '{kind: KIND_PENDING, peer_ip: key_q, peer_mac: '0, last: 1'b0};
        end else begin
          mem_we = 1'b1;
          mem_wa = tgt;
          mem_wd = '{ip: key_q, mac: '0, life: res_life_q, retries: retry_lim_q};
          st_we = 1'b1;
          st_wa = tgt;
          st_wd = ST_RESOLVING;
          pr_v_d = 1'b1;
          pr_d = '{kind: KIND_REQUEST, peer_ip: key_q, peer_mac: '0, last: 1'b0};
        end
      end
      S_EMIT2: begin
        if (slot_free) begin
          push = pr_v_q;
          pr_v_d = 1'b1;
          pr_d = '{kind: KIND_PENDING, peer_ip: key_q, peer_mac: '0, last: 1'b0};
        end
      end
      S_TPROC: begin
        if (!t_emit || slot_free) begin
          if (idx_q != LastIdx) idx_d = idx_q + idx_t'(1);
          if (t_live && !t_expire) begin
            mem_we = 1'b1;
            mem_wd.life = rd_q.life - period_q;
          end else if (t_free_it) begin
            st_we = 1'b1;
            st_wd = ST_FREE;
          end else if (t_expire) begin
            mem_we = 1'b1;
            mem_wd.life = res_life_q;
            mem_wd.retries = (cur_st == ST_RESOLVING) ? rd_q.retries - 8'd1 : retry_lim_q;
            st_we = 1'b1;
            st_wd = ST_RESOLVING;
          end
          if (t_emit) begin
            push = pr_v_q;
            n_d = n_q + CntW'(1);
            pr_v_d = 1'b1;
            pr_d = '{kind: KIND_REQUEST, peer_ip: rd_q.ip, peer_mac: '0, last: 1'b0};
          end
        end
      end
      S_FLUSH: begin
        if (pr_v_q && out_free) begin
          push = 1'b1;
          push_last = 1'b1;
          pr_v_d = 1'b0;
        end
      end
      default: ;
    endcase

    out_d = out_q;
    out_v_d = out_v_q && !out_ready_i;
    if (push) begin
      out_v_d = 1'b1;
      out_d = pr_q;
      out_d.last = push_last;
    end
  end

  // table ram, one read port with registered data and one write port
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_q <= mem[idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TableEntries; i++) st_q[i] <= ST_FREE;
    end else if (st_we) begin
      st_q[st_wa] <= st_wd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_ip_q <= '0;
      period_q <= 16'd1;
      ok_life_q <= 16'd5;
      res_life_q <= 16'd1;
      retry_lim_q <= 8'd4;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_LOCAL_IP:     local_ip_q <= cfg_data_i;
        REG_TIMER_PERIOD: period_q <= cfg_data_i[15:0];
        REG_OK_LIFE:      ok_life_q <= cfg_data_i[15:0];
        REG_RES_LIFE:     res_life_q <= cfg_data_i[15:0];
        REG_RETRY_LIMIT:  retry_lim_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pr_v_q <= 1'b0;
      out_v_q <= 1'b0;
      chk_v_q <= 1'b0;
      iss_done_q <= 1'b0;
      found_q <= 1'b0;
      free_found_q <= 1'b0;
      n_q <= '0;
      idx_q <= '0;
    end else begin
      state_q <= state_d;
      pr_v_q <= pr_v_d;
      out_v_q <= out_v_d;
      chk_v_q <= chk_v_d;
      iss_done_q <= iss_done_d;
      found_q <= found_d;
      free_found_q <= free_found_d;
      n_q <= n_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    smac_q <= smac_d;
    learn_q <= learn_d;
    reply_q <= reply_d;
    chk_idx_q <= chk_idx_d;
    hit_idx_q <= hit_idx_d;
    free_idx_q <= free_idx_d;
    vict_idx_q <= vict_idx_d;
    hit_st_q <= hit_st_d;
    hit_mac_q <= hit_mac_d;
    vict_life_q <= vict_life_d;
    pr_q <= pr_d;
    out_q <= out_d;
  end

  a_we_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == S_DECIDE || state_q == S_TPROC))
    else $error("table write outside a write state");

  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !pr_v_q)
    else $error("staged result left behind at idle");

  a_st_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_we |-> (st_wd == ST_FREE || st_wd == ST_OK || st_wd == ST_RESOLVING))
    else $error("bad status code written");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !out_ready_i |=> out_v_q && $stable(out_q))
    else $error("output beat lost under stall");

endmodule
